// ----- rtl/keypad_debounce_hid_mapper_defines.svh -----
// assertion macros used by the keypad debounce rtl
`ifndef KEYPAD_DEBOUNCE_HID_MAPPER_DEFINES_SVH
`define KEYPAD_DEBOUNCE_HID_MAPPER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KDH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KDH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kdh_pkg.sv -----
// types, constants and lookup functions of the keypad debounce and hid mapper
`default_nettype none

package kdh_pkg;

    localparam int unsigned KEY_W    = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned BTN_W    = 4;
    localparam int unsigned USAGE_W  = 8;
    localparam int unsigned TICK_W   = 8;

    localparam logic [TICK_W-1:0]  DEBOUNCE_TICKS_RESET = 8'd50;
    localparam logic [USAGE_W-1:0] USAGE_NONE           = 8'h00;
    localparam logic [USAGE_W-1:0] USAGE_BTN0           = 8'h39;
    localparam logic [USAGE_W-1:0] USAGE_BTN1           = 8'h0C;
    localparam logic [USAGE_W-1:0] USAGE_BTN2           = 8'h04;
    localparam logic [USAGE_W-1:0] USAGE_BTN3           = 8'h28;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_FALLING  = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_RISING   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [USAGE_W-1:0] keypad_usage;
        logic               indicator;
        t_phase             phase;
    } t_deb_result;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_key_sel;

    // lowest column first, then lowest row
    function automatic t_key_sel encode_key(input logic [KEY_W-1:0] m);
        t_key_sel sel;
        sel.found = 1'b0;
        sel.idx   = '0;
        for (int col = 3; col >= 0; col--) begin
            for (int row = 3; row >= 0; row--) begin
                if (m[row*4 + col]) begin
                    sel.found = 1'b1;
                    sel.idx   = IDX_W'(row*4 + col);
                end
            end
        end
        return sel;
    endfunction

    function automatic logic [USAGE_W-1:0] key_usage(input logic [IDX_W-1:0] idx);
        logic [USAGE_W-1:0] u;
        case (idx)
            4'd0:    u = 8'h1E;
            4'd1:    u = 8'h1F;
            4'd2:    u = 8'h20;
            4'd3:    u = 8'h57;
            4'd4:    u = 8'h21;
            4'd5:    u = 8'h22;
            4'd6:    u = 8'h23;
            4'd7:    u = 8'h56;
            4'd8:    u = 8'h24;
            4'd9:    u = 8'h25;
            4'd10:   u = 8'h26;
            4'd11:   u = 8'h55;
            4'd12:   u = 8'h53;
            4'd13:   u = 8'h27;
            4'd14:   u = 8'h58;
            default: u = 8'h54;
        endcase
        return u;
    endfunction

    function automatic logic [USAGE_W-1:0] button_usage(input logic [BTN_W-1:0] b);
        logic [USAGE_W-1:0] u;
        if (b[0]) begin
            u = USAGE_BTN0;
        end else if (b[1]) begin
            u = USAGE_BTN1;
        end else if (b[2]) begin
            u = USAGE_BTN2;
        end else if (b[3]) begin
            u = USAGE_BTN3;
        end else begin
            u = USAGE_NONE;
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kdh_debounce.sv -----
// keypad debounce state machine with key encoder and usage lookup
`default_nettype none

`include "keypad_debounce_hid_mapper_defines.svh"

module kdh_debounce (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic [kdh_pkg::KEY_W-1:0]     i_key_matrix,
    input  wire logic [kdh_pkg::TICK_W-1:0]    i_debounce_ticks,
    output kdh_pkg::t_deb_result               o_result
);

    kdh_pkg::t_phase                  r_phase, n_phase;
    logic [kdh_pkg::TICK_W-1:0]       r_tick, n_tick;
    logic [kdh_pkg::IDX_W-1:0]        r_last_key, n_last_key;
    logic                             r_indicator, n_indicator;
    logic [kdh_pkg::USAGE_W-1:0]      n_usage;
    logic [kdh_pkg::TICK_W-1:0]       tick_inc;
    logic                             reached;
    kdh_pkg::t_key_sel                sel;

    assign sel      = kdh_pkg::encode_key(i_key_matrix);
    assign tick_inc = r_tick + kdh_pkg::TICK_W'(1);
    assign reached  = (tick_inc >= i_debounce_ticks);

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_last_key  = r_last_key;
        n_indicator = r_indicator;
        n_usage     = kdh_pkg::USAGE_NONE;
        case (r_phase)
            kdh_pkg::PH_RELEASED: begin
                if (sel.found) begin
                    n_last_key = sel.idx;
                    n_phase    = kdh_pkg::PH_FALLING;
                end
            end
            kdh_pkg::PH_FALLING: begin
                n_tick = tick_inc;
                if (reached) begin
                    n_tick = '0;
                    if (sel.found) begin
                        n_last_key  = sel.idx;
                        n_phase     = kdh_pkg::PH_PRESSED;
                        n_usage     = kdh_pkg::key_usage(sel.idx);
                        n_indicator = 1'b1;
                    end else begin
                        n_phase = kdh_pkg::PH_RELEASED;
                    end
                end
            end
            kdh_pkg::PH_PRESSED: begin
                if (sel.found) begin
                    n_last_key = sel.idx;
                end else begin
                    n_phase = kdh_pkg::PH_RISING;
                end
            end
            default: begin
                n_tick = tick_inc;
                if (reached) begin
                    n_tick = '0;
                    if (sel.found) begin
                        n_last_key = sel.idx;
                        n_phase    = kdh_pkg::PH_PRESSED;
                    end else begin
                        n_phase     = kdh_pkg::PH_RELEASED;
                        n_indicator = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= kdh_pkg::PH_RELEASED;
            r_tick      <= '0;
            r_last_key  <= '0;
            r_indicator <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_last_key  <= n_last_key;
            r_indicator <= n_indicator;
        end
    end

    assign o_result.keypad_usage = n_usage;
    assign o_result.indicator    = n_indicator;
    assign o_result.phase        = n_phase;

    `KDH_ASSERT_IMPL(a_ind_follows_phase, i_clk, i_rst_n, 1'b1,
        r_indicator == (r_phase == kdh_pkg::PH_PRESSED || r_phase == kdh_pkg::PH_RISING),
        "indicator out of step with debounce phase")
    `KDH_ASSERT_IMPL(a_tick_idle_zero, i_clk, i_rst_n,
        r_phase == kdh_pkg::PH_RELEASED || r_phase == kdh_pkg::PH_PRESSED,
        r_tick == '0, "tick count not cleared outside falling or rising")
    `KDH_ASSERT_NEXT(a_confirm_press, i_clk, i_rst_n,
        i_adv && r_phase == kdh_pkg::PH_FALLING && reached && sel.found,
        r_phase == kdh_pkg::PH_PRESSED && r_indicator && r_last_key == $past(sel.idx),
        "confirmed press did not reach pressed")
    `KDH_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_adv,
        $stable(r_phase) && $stable(r_tick) && $stable(r_last_key),
        "debounce state moved without a request")

endmodule

`default_nettype wire

// ----- rtl/keypad_debounce_hid_mapper.sv -----
// top level: request pipeline, threshold register and button priority
// an accepted request waits in the input stage and moves to the result register once the output side is free
// throughput: one request per cycle while the output is not stalled, set by the single-pass debounce update
// a held result does not block a new request while the input stage is free
// reset: synchronous active-low; phase released, counters and key cleared,
// indicator off, threshold 50, both stages empty
`default_nettype none

module keypad_debounce_hid_mapper (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [kdh_pkg::TICK_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [kdh_pkg::KEY_W-1:0]    i_key_matrix,
    input  wire logic [kdh_pkg::BTN_W-1:0]    i_buttons,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [kdh_pkg::USAGE_W-1:0]       o_button_usage,
    output logic [kdh_pkg::USAGE_W-1:0]       o_keypad_usage,
    output logic                              o_press_indicator,
    output logic [1:0]                        o_debounce_phase
);

    logic [kdh_pkg::TICK_W-1:0]   r_debounce_ticks;
    logic                         r_in_valid;
    logic [kdh_pkg::KEY_W-1:0]    r_key_matrix;
    logic [kdh_pkg::BTN_W-1:0]    r_buttons;
    logic                         r_out_valid;
    logic [kdh_pkg::USAGE_W-1:0]  r_button_usage;
    logic [kdh_pkg::USAGE_W-1:0]  r_keypad_usage;
    logic                         r_press_indicator;
    logic [1:0]                   r_debounce_phase;
    logic                         out_free;
    logic                         adv;
    logic                         accept;
    kdh_pkg::t_deb_result         deb;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= kdh_pkg::DEBOUNCE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_debounce_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_matrix <= i_key_matrix;
            r_buttons    <= i_buttons;
        end
    end

    kdh_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_key_matrix     (r_key_matrix),
        .i_debounce_ticks (r_debounce_ticks),
        .o_result         (deb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_button_usage    <= kdh_pkg::button_usage(r_buttons);
            r_keypad_usage    <= deb.keypad_usage;
            r_press_indicator <= deb.indicator;
            r_debounce_phase  <= 2'(deb.phase);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_button_usage    = r_button_usage;
    assign o_keypad_usage    = r_keypad_usage;
    assign o_press_indicator = r_press_indicator;
    assign o_debounce_phase  = r_debounce_phase;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the keypad debounce and hid mapper: directed and random tick streams, self-checked
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 500000;

    // usage per key index, entry 0 in the low byte
    localparam logic [127:0] KEY_USAGE_ROM = {
        8'h54, 8'h58, 8'h27, 8'h53, 8'h55, 8'h26, 8'h25, 8'h24,
        8'h56, 8'h23, 8'h22, 8'h21, 8'h57, 8'h20, 8'h1F, 8'h1E
    };

    typedef struct packed {
        logic [7:0]      btn_usage;
        logic [7:0]      key_usage;
        logic            lamp;
        kdh_pkg::t_phase phase;
    } t_tick_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        i_in_valid = 1'b0;
    logic [15:0] i_key_matrix = 16'd0;
    logic [3:0]  i_buttons = 4'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_button_usage;
    logic [7:0]  o_keypad_usage;
    logic        o_press_indicator;
    logic [1:0]  o_debounce_phase;

    t_tick_result    results_due[$];
    kdh_pkg::t_phase model_phase = kdh_pkg::PH_RELEASED;
    logic [7:0]      model_count = 8'd0;
    logic            model_lamp = 1'b0;
    logic [7:0]      model_threshold = kdh_pkg::DEBOUNCE_TICKS_RESET;

    int  tick_sent_count = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;

    keypad_debounce_hid_mapper uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_key_matrix      (i_key_matrix),
        .i_buttons         (i_buttons),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_button_usage    (o_button_usage),
        .o_keypad_usage    (o_keypad_usage),
        .o_press_indicator (o_press_indicator),
        .o_debounce_phase  (o_debounce_phase)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keypad_debounce_hid_mapper regression: fail");
            $finish;
        end
    end

    function automatic t_tick_result predict_tick(input logic [15:0] keys,
                                                  input logic [3:0] btns);
        t_tick_result r;
        logic         hit;
        logic [3:0]   sel;
        logic [3:0]   pos;
        hit = 1'b0;
        sel = 4'd0;
        // column-major scan, so the lowest column wins, then the lowest row
        for (int p = 0; p < 16; p++) begin
            pos = {p[1:0], p[3:2]};
            if (!hit && keys[pos]) begin
                hit = 1'b1;
                sel = pos;
            end
        end
        r.key_usage = 8'h00;
        case (model_phase)
            kdh_pkg::PH_RELEASED: begin
                if (hit) begin
                    model_phase = kdh_pkg::PH_FALLING;
                end
            end
            kdh_pkg::PH_FALLING: begin
                model_count = model_count + 8'd1;
                if (model_count >= model_threshold) begin
                    model_count = 8'd0;
                    if (hit) begin
                        model_phase = kdh_pkg::PH_PRESSED;
                        r.key_usage = KEY_USAGE_ROM[sel*8 +: 8];
                        model_lamp  = 1'b1;
                    end else begin
                        model_phase = kdh_pkg::PH_RELEASED;
                    end
                end
            end
            kdh_pkg::PH_PRESSED: begin
                if (!hit) begin
                    model_phase = kdh_pkg::PH_RISING;
                end
            end
            default: begin
                model_count = model_count + 8'd1;
                if (model_count >= model_threshold) begin
                    model_count = 8'd0;
                    if (hit) begin
                        model_phase = kdh_pkg::PH_PRESSED;
                    end else begin
                        model_phase = kdh_pkg::PH_RELEASED;
                        model_lamp  = 1'b0;
                    end
                end
            end
        endcase
        casez (btns)
            4'b???1: r.btn_usage = kdh_pkg::USAGE_BTN0;
            4'b??10: r.btn_usage = kdh_pkg::USAGE_BTN1;
            4'b?100: r.btn_usage = kdh_pkg::USAGE_BTN2;
            4'b1000: r.btn_usage = kdh_pkg::USAGE_BTN3;
            default: r.btn_usage = kdh_pkg::USAGE_NONE;
        endcase
        r.lamp  = model_lamp;
        r.phase = model_phase;
        return r;
    endfunction

    // result side: random stall bursts until the unpaced part
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 10);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tick_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with none expected, button %h keypad %h lamp %b phase %0d",
                         $time, o_button_usage, o_keypad_usage, o_press_indicator,
                         o_debounce_phase);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (o_button_usage !== want.btn_usage) begin
                    $display("%0t: button usage expected %h got %h",
                             $time, want.btn_usage, o_button_usage);
                    mismatches++;
                end
                if (o_keypad_usage !== want.key_usage) begin
                    $display("%0t: keypad usage expected %h got %h",
                             $time, want.key_usage, o_keypad_usage);
                    mismatches++;
                end
                if (o_press_indicator !== want.lamp) begin
                    $display("%0t: press indicator expected %b got %b",
                             $time, want.lamp, o_press_indicator);
                    mismatches++;
                end
                if (o_debounce_phase !== want.phase) begin
                    $display("%0t: debounce phase expected %0d got %0d",
                             $time, want.phase, o_debounce_phase);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_tick(input logic [15:0] keys, input logic [3:0] btns);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_key_matrix <= keys;
        i_buttons    <= btns;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        results_due.push_back(predict_tick(keys, btns));
        tick_sent_count++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] ticks);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        model_threshold = ticks;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one press with bounce and hold, then one release with bounce and gap
    task automatic press_and_release(input int thr);
        logic [15:0] keys;
        int          eff;
        int          n_hold;
        int          n_free;
        eff = (thr == 0) ? 1 : thr;
        if ($urandom_range(0, 2) != 0) begin
            keys = 16'h1 << $urandom_range(0, 15);
        end else begin
            keys = 16'($urandom_range(1, 16'hFFFF));
        end
        repeat ($urandom_range(0, 3)) begin
            send_tick(keys, 4'($urandom));
            send_tick(16'h0000, 4'($urandom));
        end
        n_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                             : eff + $urandom_range(1, 6);
        repeat (n_hold) begin
            if ($urandom_range(0, 15) == 0) begin
                send_tick(16'($urandom), 4'($urandom));
            end else begin
                send_tick(keys, 4'($urandom));
            end
        end
        repeat ($urandom_range(0, 3)) begin
            send_tick(16'h0000, 4'($urandom));
            send_tick(keys, 4'($urandom));
        end
        n_free = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff)
                                             : eff + $urandom_range(1, 6);
        repeat (n_free) begin
            if ($urandom_range(0, 15) == 0) begin
                send_tick(16'($urandom), 4'($urandom));
            end else begin
                send_tick(16'h0000, 4'($urandom));
            end
        end
    endtask

    task automatic run_presses(input int thr, input int count);
        int target;
        target = tick_sent_count + count;
        while (tick_sent_count < target) begin
            press_and_release(thr);
        end
    endtask

    task automatic test_button_priority();
        send_tick(16'h0000, 4'h0);
        send_tick(16'h0000, 4'h1);
        send_tick(16'h0000, 4'h2);
        send_tick(16'h0000, 4'h4);
        send_tick(16'h0000, 4'h8);
        send_tick(16'h0000, 4'hF);
        send_tick(16'h0000, 4'hE);
        send_tick(16'h0000, 4'hC);
    endtask

    task automatic test_zero_threshold();
        write_threshold(8'd0);
        // all keys closed, key 0 wins
        send_tick(16'hFFFF, 4'($urandom));
        send_tick(16'hFFFF, 4'($urandom));
        // release bounce, back to pressed
        send_tick(16'h0000, 4'($urandom));
        send_tick(16'hFFFF, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        // press bounce, back to released
        send_tick(16'h0012, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        // top key
        send_tick(16'h8000, 4'($urandom));
        send_tick(16'h8000, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        // two keys in column 0, lower row wins
        send_tick(16'h0110, 4'($urandom));
        send_tick(16'h0110, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
        send_tick(16'h0000, 4'($urandom));
    endtask

    task automatic test_min_threshold();
        write_threshold(8'd1);
        run_presses(1, 60);
    endtask

    task automatic test_random_threshold();
        int thr;
        repeat (3) begin
            thr = $urandom_range(2, 12);
            write_threshold(8'(thr));
            run_presses(thr, 30);
        end
    endtask

    task automatic test_max_threshold();
        write_threshold(8'd255);
        press_and_release(255);
    endtask

    task automatic test_reset_threshold();
        write_threshold(kdh_pkg::DEBOUNCE_TICKS_RESET);
        run_presses(50, 60);
    endtask

    task automatic test_unpaced();
        int thr;
        quiet = 1'b1;
        thr = $urandom_range(1, 6);
        write_threshold(8'(thr));
        run_presses(thr, 80);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_button_priority();
        test_zero_threshold();
        test_min_threshold();
        test_random_threshold();
        test_max_threshold();
        test_reset_threshold();
        test_unpaced();
        drain_results();
        $display("%0d ticks sent, %0d results checked, %0d mismatches",
                 tick_sent_count, results_checked, mismatches);
        $display("thresholds 0, 1, 50, 255 and random, with bounce, noise and stalls");
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("keypad_debounce_hid_mapper regression: pass");
        end else begin
            $display("keypad_debounce_hid_mapper regression: fail");
        end
        $finish;
    end

endmodule
